@@ hw/rtl/elc_pkg.sv @@
// Shared types, constants and floor-mask helpers for the elevator LOOK controller.
`timescale 1ns / 1ps

package elc_pkg;

   localparam int FLOORS = 8;
   localparam int FLOOR_W = 3;
   localparam int MASK_W = 8;
   localparam int TICK_W = 16;
   localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
   localparam logic [TICK_W-1:0] TRAVEL_RESET = 16'd1000;
   localparam logic [TICK_W-1:0] SERVICE_RESET = 16'd1000;

   localparam logic CSR_TRAVEL = 1'b0;
   localparam logic CSR_SERVICE = 1'b1;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_REQUEST = 1'b1;

   typedef enum logic [1:0] {
      HD_IDLE = 2'd0,
      HD_UP   = 2'd1,
      HD_DOWN = 2'd2
   } heading_type;

   typedef enum logic [1:0] {
      PH_IDLE      = 2'd0,
      PH_MOVING    = 2'd1,
      PH_STOPPING  = 2'd2,
      PH_SERVICING = 2'd3
   } phase_type;

   typedef struct packed {
      logic [MASK_W-1:0]  mask;
      logic [FLOOR_W-1:0] floor;
      heading_type        heading;
      phase_type          phase;
      logic               door;
      logic [TICK_W-1:0]  elapsed;
      logic               travel_wait;
      logic               service_wait;
   } car_state_type;

   function automatic logic any_above(input logic [MASK_W-1:0] mask,
                                      input logic [FLOOR_W-1:0] floor);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < FLOORS; i++) begin
         if (i > int'(floor) && mask[i]) hit = 1'b1;
      end
      return hit;
   endfunction

   function automatic logic any_below(input logic [MASK_W-1:0] mask,
                                      input logic [FLOOR_W-1:0] floor);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < FLOORS; i++) begin
         if (i < int'(floor) && mask[i]) hit = 1'b1;
      end
      return hit;
   endfunction

endpackage

@@ hw/rtl/elc_step.sv @@
// Next-state logic for one controller item: request capture or one tick step.
`timescale 1ns / 1ps

module elc_step
   import elc_pkg::*;
(
   input  logic                cur_kind,
   input  logic [FLOOR_W-1:0]  cur_floor,
   input  logic [TICK_W-1:0]   travel_ticks,
   input  logic [TICK_W-1:0]   service_ticks,
   input  car_state_type       state_cur,
   output car_state_type       state_nxt,
   output logic                floor_changed
);

   logic [MASK_W-1:0] cleared_mask;

   always_comb begin
      cleared_mask = state_cur.mask & ~(MASK_W'(1) << state_cur.floor);
   end

   always_comb begin
      state_nxt = state_cur;
      floor_changed = 1'b0;
      if (cur_kind == KIND_REQUEST) begin
         if (int'(cur_floor) < FLOORS) begin
            state_nxt.mask = state_cur.mask | (MASK_W'(1) << cur_floor);
         end
      end else begin
         if (state_cur.elapsed != TICK_MAX) begin
            state_nxt.elapsed = state_cur.elapsed + TICK_W'(1);
         end
         case (state_cur.phase)
            PH_IDLE: begin
               if (state_cur.mask != '0) begin
                  if (state_cur.mask[state_cur.floor]) begin
                     state_nxt.phase = PH_STOPPING;
                  end else if (any_above(state_cur.mask, state_cur.floor)) begin
                     state_nxt.heading = HD_UP;
                     state_nxt.phase = PH_MOVING;
                  end else if (any_below(state_cur.mask, state_cur.floor)) begin
                     state_nxt.heading = HD_DOWN;
                     state_nxt.phase = PH_MOVING;
                  end
               end else begin
                  if (state_cur.floor == '0) begin
                     state_nxt.heading = HD_IDLE;
                  end else begin
                     state_nxt.mask = state_cur.mask | MASK_W'(1);
                  end
                  state_nxt.phase = PH_IDLE;
               end
            end
            PH_MOVING: begin
               if (state_cur.mask[state_cur.floor]) begin
                  state_nxt.phase = PH_STOPPING;
                  state_nxt.travel_wait = 1'b0;
               end else if (!state_cur.travel_wait) begin
                  state_nxt.elapsed = '0;
                  state_nxt.travel_wait = 1'b1;
               end else if (state_nxt.elapsed >= travel_ticks) begin
                  if (state_cur.heading == HD_UP &&
                      int'(state_cur.floor) < FLOORS - 1) begin
                     state_nxt.floor = state_cur.floor + FLOOR_W'(1);
                     floor_changed = 1'b1;
                  end else if (state_cur.heading == HD_DOWN && state_cur.floor != '0) begin
                     state_nxt.floor = state_cur.floor - FLOOR_W'(1);
                     floor_changed = 1'b1;
                  end
                  state_nxt.travel_wait = 1'b0;
               end
            end
            PH_STOPPING: begin
               state_nxt.door = 1'b1;
               state_nxt.phase = PH_SERVICING;
            end
            default: begin
               if (!state_cur.service_wait) begin
                  state_nxt.elapsed = '0;
                  state_nxt.service_wait = 1'b1;
               end else if (state_nxt.elapsed >= service_ticks) begin
                  state_nxt.service_wait = 1'b0;
                  state_nxt.mask = cleared_mask;
                  state_nxt.door = 1'b0;
                  state_nxt.phase = PH_MOVING;
                  case (state_cur.heading)
                     HD_UP: begin
                        if (any_above(cleared_mask, state_cur.floor)) begin
                           state_nxt.heading = HD_UP;
                        end else if (any_below(cleared_mask, state_cur.floor)) begin
                           state_nxt.heading = HD_DOWN;
                        end else begin
                           state_nxt.phase = PH_IDLE;
                        end
                     end
                     HD_DOWN: begin
                        if (any_below(cleared_mask, state_cur.floor)) begin
                           state_nxt.heading = HD_DOWN;
                        end else if (any_above(cleared_mask, state_cur.floor)) begin
                           state_nxt.heading = HD_UP;
                        end else begin
                           state_nxt.phase = PH_IDLE;
                        end
                     end
                     default: begin
                        if (any_above(cleared_mask, state_cur.floor)) begin
                           state_nxt.heading = HD_UP;
                        end else if (any_below(cleared_mask, state_cur.floor)) begin
                           state_nxt.heading = HD_DOWN;
                        end else begin
                           state_nxt.phase = PH_IDLE;
                        end
                     end
                  endcase
                  if (state_nxt.phase == PH_IDLE) begin
                     if (state_cur.floor == '0) begin
                        state_nxt.heading = HD_IDLE;
                     end else begin
                        state_nxt.mask = cleared_mask | MASK_W'(1);
                     end
                  end
               end
            end
         endcase
      end
   end

endmodule

@@ hw/rtl/elevator_look_controller_top.sv @@
// Top level of the elevator LOOK controller: input register, car state and result register.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_kind, req_floor
//   rsp     | out       | rsp_valid/rsp_stall | floor_now, heading, phase, door_open,
//           |           |                     | pending, floor_changed
//   csr     | in        | csr_write           | csr_index, csr_data
//
// One transfer per cycle in each direction while neither side stalls; an item's result is
// valid once the item has passed the input register and then the result register.
// Synchronous reset clears the car state, both valids and reloads both tick registers.
// A stalled result holds; the input register still takes one transfer behind it.
`timescale 1ns / 1ps

module elevator_look_controller_top
   import elc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_kind,
   input  logic [FLOOR_W-1:0]  req_floor,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [FLOOR_W-1:0]  rsp_floor_now,
   output logic [1:0]          rsp_heading,
   output logic [1:0]          rsp_phase,
   output logic                rsp_door_open,
   output logic [MASK_W-1:0]   rsp_pending,
   output logic                rsp_floor_changed,
   input  logic                csr_write,
   input  logic                csr_index,
   input  logic [TICK_W-1:0]   csr_data
);

   logic               in_valid_ff;
   logic               in_kind_ff;
   logic [FLOOR_W-1:0] in_floor_ff;
   logic               out_valid_ff;
   logic [FLOOR_W-1:0] out_floor_ff;
   logic [1:0]         out_heading_ff;
   logic [1:0]         out_phase_ff;
   logic               out_door_ff;
   logic [MASK_W-1:0]  out_pending_ff;
   logic               out_changed_ff;
   logic [TICK_W-1:0]  travel_ff;
   logic [TICK_W-1:0]  service_ff;
   car_state_type      car_ff;
   car_state_type      car_in;
   logic               changed_in;
   logic               advance;
   logic               step;

   assign advance = !out_valid_ff || !rsp_stall;
   assign step = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   elc_step u_step (
      .cur_kind      (in_kind_ff),
      .cur_floor     (in_floor_ff),
      .travel_ticks  (travel_ff),
      .service_ticks (service_ff),
      .state_cur     (car_ff),
      .state_nxt     (car_in),
      .floor_changed (changed_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         travel_ff <= TRAVEL_RESET;
         service_ff <= SERVICE_RESET;
         car_ff <= '{mask: '0, floor: '0, heading: HD_IDLE, phase: PH_IDLE, door: 1'b0,
                     elapsed: '0, travel_wait: 1'b0, service_wait: 1'b0};
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_TRAVEL) begin
               travel_ff <= csr_data;
            end else begin
               service_ff <= csr_data;
            end
         end
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (step) begin
            car_ff <= car_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_kind_ff <= req_kind;
         in_floor_ff <= req_floor;
      end
      if (step) begin
         out_floor_ff <= car_in.floor;
         out_heading_ff <= car_in.heading;
         out_phase_ff <= car_in.phase;
         out_door_ff <= car_in.door;
         out_pending_ff <= car_in.mask;
         out_changed_ff <= changed_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_floor_now = out_floor_ff;
   assign rsp_heading = out_heading_ff;
   assign rsp_phase = out_phase_ff;
   assign rsp_door_open = out_door_ff;
   assign rsp_pending = out_pending_ff;
   assign rsp_floor_changed = out_changed_ff;

endmodule

@@ hw/rtl/elc_checker.sv @@
// Port-level checker for the elevator LOOK controller, bound to the top level.
`timescale 1ns / 1ps

module elc_checker
   import elc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [FLOOR_W-1:0]  rsp_floor_now,
   input  logic [1:0]          rsp_heading,
   input  logic [1:0]          rsp_phase,
   input  logic                rsp_door_open,
   input  logic [MASK_W-1:0]   rsp_pending,
   input  logic                rsp_floor_changed
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_floor_now) &&
      $stable(rsp_pending) && $stable(rsp_phase))
      else $error("stalled result changed");

   a_door_service: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_door_open == (rsp_phase == PH_SERVICING))
      else $error("door state does not match servicing phase");

   a_change_moving: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_floor_changed |-> rsp_phase == PH_MOVING && rsp_heading != HD_IDLE)
      else $error("floor changed outside a move");

   a_moving_heading: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_phase == PH_MOVING |-> rsp_heading == HD_UP || rsp_heading == HD_DOWN)
      else $error("moving car without heading");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind elevator_look_controller_top elc_checker u_elc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_floor_now     (rsp_floor_now),
   .rsp_heading       (rsp_heading),
   .rsp_phase         (rsp_phase),
   .rsp_door_open     (rsp_door_open),
   .rsp_pending       (rsp_pending),
   .rsp_floor_changed (rsp_floor_changed)
);
